// ----- rtl/bpr_pkg.sv -----
// Shared types and constants for the buffer-pool replacement unit.
// Used by bpr_ctrl, bpr_datapath and buffer_pool_replacement_unit; depends on nothing.
package bpr_pkg;

    localparam int ENTRIES_DEF = 16;
    localparam int SLOT_W      = 4;
    localparam int FILE_W      = 16;
    localparam int BLOCK_W     = 24;
    localparam int COUNT_W     = 8;
    localparam logic [COUNT_W-1:0] COUNT_RESET = 8'd100;

    typedef enum logic [2:0] {
        OP_LOAD      = 3'd0,
        OP_ACCESS    = 3'd1,
        OP_SET_DIRTY = 3'd2,
        OP_CLR_DIRTY = 3'd3,
        OP_LOCK      = 3'd4,
        OP_UNLOCK    = 3'd5,
        OP_RELEASE   = 3'd6
    } t_op;

    typedef enum logic [2:0] {
        ST_HIT    = 3'd0,
        ST_FILL   = 3'd1,
        ST_VICTIM = 3'd2,
        ST_NONE   = 3'd3,
        ST_DONE   = 3'd4
    } t_status;

    typedef struct packed {
        t_op                command;
        logic [FILE_W-1:0]  file_id;
        logic [BLOCK_W-1:0] block_number;
        logic [SLOT_W-1:0]  slot;
    } t_item;

    typedef struct packed {
        t_status            status;
        logic [SLOT_W-1:0]  result_slot;
        logic               writeback;
        logic [FILE_W-1:0]  wb_file_id;
        logic [BLOCK_W-1:0] wb_block_number;
        logic               last;
    } t_result;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic resolve;
        logic vstep;
        logic replace;
        logic rstep;
        logic rclose;
        logic slotop;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic any_hit;
        logic any_free;
        logic idx_last;
    } t_dp_sts;

endpackage

// ----- rtl/bpr_ctrl.sv -----
// Sequencing state machine of the buffer-pool replacement unit.
// Depends on bpr_pkg; drives bpr_datapath through t_dp_cmd and reads t_dp_sts.
module bpr_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  bpr_pkg::t_op     i_cmd,
    input  bpr_pkg::t_dp_sts i_sts,
    output logic             o_busy,
    output bpr_pkg::t_dp_cmd o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_RESOLVE,
        S_VSCAN,
        S_REPLACE,
        S_RSCAN,
        S_RCLOSE,
        S_SLOTOP
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    unique case (i_cmd)
                        bpr_pkg::OP_LOAD:    n_state = S_RESOLVE;
                        bpr_pkg::OP_RELEASE: n_state = S_RSCAN;
                        default:             n_state = S_SLOTOP;
                    endcase
                end
            end
            S_RESOLVE: begin
                if (i_sts.any_hit || i_sts.any_free) begin
                    n_state = S_IDLE;
                end else begin
                    n_state = S_VSCAN;
                end
            end
            S_VSCAN: begin
                if (i_sts.idx_last) begin
                    n_state = S_REPLACE;
                end
            end
            S_RSCAN: begin
                if (i_sts.idx_last) begin
                    n_state = S_RCLOSE;
                end
            end
            S_REPLACE, S_RCLOSE, S_SLOTOP: begin
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy = (r_state != S_IDLE);

    always_comb begin
        o_cmd         = '0;
        o_cmd.capture = i_start && (r_state == S_IDLE);
        // A resolve only completes the load when there is a hit or a free entry.
        o_cmd.resolve = (r_state == S_RESOLVE) && (i_sts.any_hit || i_sts.any_free);
        o_cmd.vstep   = (r_state == S_VSCAN);
        o_cmd.replace = (r_state == S_REPLACE);
        o_cmd.rstep   = (r_state == S_RSCAN);
        o_cmd.rclose  = (r_state == S_RCLOSE);
        o_cmd.slotop  = (r_state == S_SLOTOP);
    end

endmodule

// ----- rtl/bpr_datapath.sv -----
// Directory entries, parallel tag compare, victim and release scans, result register.
// Depends on bpr_pkg; commanded by bpr_ctrl.
module bpr_datapath #(
    parameter int ENTRIES = bpr_pkg::ENTRIES_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  bpr_pkg::t_dp_cmd             i_cmd,
    input  bpr_pkg::t_item               i_item,
    input  logic                         i_cfg_we,
    input  logic [bpr_pkg::COUNT_W-1:0]  i_cfg_data,
    output bpr_pkg::t_dp_sts             o_sts,
    output logic                         o_valid,
    output bpr_pkg::t_result             o_result
);

    localparam int IW = $clog2(ENTRIES);
    localparam int SW = bpr_pkg::SLOT_W;
    localparam int CW = bpr_pkg::COUNT_W;
    localparam int XW = ((IW > SW) ? IW : SW) + 1;

    logic [ENTRIES-1:0]              r_valid;
    logic [ENTRIES-1:0]              r_dirty;
    logic [ENTRIES-1:0]              r_locked;
    logic [bpr_pkg::FILE_W-1:0]      r_file  [ENTRIES];
    logic [bpr_pkg::BLOCK_W-1:0]     r_block [ENTRIES];
    logic [CW-1:0]                   r_count [ENTRIES];

    bpr_pkg::t_item                  r_req;
    logic [ENTRIES-1:0]              r_hit;
    logic [ENTRIES-1:0]              r_rel;
    logic [ENTRIES-1:0]              r_free;
    logic [IW-1:0]                   r_idx;
    logic [IW-1:0]                   r_victim;
    logic [CW-1:0]                   r_best;
    logic                            r_found;
    logic [CW-1:0]                   r_limit;
    logic                            r_out_valid;
    bpr_pkg::t_result                r_result;
    bpr_pkg::t_result                n_result;

    logic [ENTRIES-1:0]              hit_now;
    logic [ENTRIES-1:0]              rel_now;
    logic [IW-1:0]                   hit_idx;
    logic [IW-1:0]                   free_idx;
    logic [XW-1:0]                   slot_x;
    logic                            slot_ok;
    logic [IW-1:0]                   slot_idx;
    logic [CW-1:0]                   fill_count;
    logic                            do_fill;
    logic [IW-1:0]                   fill_idx;
    logic                            do_clear;

    // Lowest set position of a vector.
    function automatic logic [IW-1:0] first_set(input logic [ENTRIES-1:0] v);
        logic [IW-1:0] res;
        res = '0;
        for (int i = ENTRIES - 1; i >= 0; i--) begin
            if (v[i]) begin
                res = IW'(i);
            end
        end
        return res;
    endfunction

    always_comb begin
        for (int i = 0; i < ENTRIES; i++) begin
            rel_now[i] = r_valid[i] && (r_file[i] == i_item.file_id);
            hit_now[i] = rel_now[i] && (r_block[i] == i_item.block_number);
        end
    end

    assign hit_idx    = first_set(r_hit);
    assign free_idx   = first_set(r_free);
    assign slot_x     = XW'(r_req.slot);
    assign slot_ok    = slot_x < XW'(ENTRIES);
    assign slot_idx   = slot_x[IW-1:0];
    assign fill_count = (r_limit != '0) ? CW'(1) : '0;

    // A load fills the first free entry on a miss, or the chosen victim.
    assign do_fill  = (i_cmd.resolve && !(|r_hit)) || (i_cmd.replace && r_found);
    assign fill_idx = i_cmd.replace ? r_victim : free_idx;
    assign do_clear = i_cmd.rstep && r_rel[r_idx];

    assign o_sts.any_hit  = |r_hit;
    assign o_sts.any_free = |r_free;
    assign o_sts.idx_last = (r_idx == IW'(ENTRIES - 1));

    // Control bits and counts of every entry.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_dirty  <= '0;
            r_locked <= '0;
            for (int i = 0; i < ENTRIES; i++) begin
                r_count[i] <= '0;
            end
        end else begin
            if (do_fill) begin
                r_valid[fill_idx]  <= 1'b1;
                r_dirty[fill_idx]  <= 1'b0;
                r_locked[fill_idx] <= 1'b0;
                r_count[fill_idx]  <= fill_count;
            end
            if (do_clear) begin
                r_valid[r_idx]  <= 1'b0;
                r_dirty[r_idx]  <= 1'b0;
                r_locked[r_idx] <= 1'b0;
                r_count[r_idx]  <= '0;
            end
            if (i_cmd.slotop && slot_ok) begin
                unique case (r_req.command)
                    bpr_pkg::OP_ACCESS: begin
                        if (r_count[slot_idx] < r_limit) begin
                            r_count[slot_idx] <= r_count[slot_idx] + CW'(1);
                        end
                    end
                    bpr_pkg::OP_SET_DIRTY: r_dirty[slot_idx]  <= 1'b1;
                    bpr_pkg::OP_CLR_DIRTY: r_dirty[slot_idx]  <= 1'b0;
                    bpr_pkg::OP_LOCK:      r_locked[slot_idx] <= 1'b1;
                    bpr_pkg::OP_UNLOCK:    r_locked[slot_idx] <= 1'b0;
                    default: ;
                endcase
            end
        end
    end

    // Tags are only looked at while the entry is valid.
    always_ff @(posedge i_clk) begin
        if (do_fill) begin
            r_file[fill_idx]  <= r_req.file_id;
            r_block[fill_idx] <= r_req.block_number;
        end
    end

    // Request capture and scan state.
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_req   <= i_item;
            r_hit   <= hit_now;
            r_rel   <= rel_now;
            r_free  <= ~r_valid;
            r_idx   <= '0;
            r_found <= 1'b0;
        end else begin
            if (i_cmd.vstep || i_cmd.rstep) begin
                r_idx <= r_idx + IW'(1);
            end
            // Ties go to the later entry, hence the less-or-equal.
            if (i_cmd.vstep && !r_locked[r_idx] &&
                (!r_found || (r_count[r_idx] <= r_best))) begin
                r_found  <= 1'b1;
                r_best   <= r_count[r_idx];
                r_victim <= r_idx;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= bpr_pkg::COUNT_RESET;
        end else if (i_cfg_we) begin
            r_limit <= i_cfg_data;
        end
    end

    // Result register: each result is shown for one cycle only.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= i_cmd.resolve || i_cmd.replace || i_cmd.rclose ||
                           i_cmd.slotop || (do_clear && r_dirty[r_idx]);
        end
    end

    always_comb begin
        n_result      = '0;
        n_result.last = 1'b1;
        if (i_cmd.resolve) begin
            if (|r_hit) begin
                n_result.status      = bpr_pkg::ST_HIT;
                n_result.result_slot = SW'(hit_idx);
            end else begin
                n_result.status      = bpr_pkg::ST_FILL;
                n_result.result_slot = SW'(free_idx);
            end
        end else if (i_cmd.replace) begin
            if (r_found) begin
                n_result.status      = bpr_pkg::ST_VICTIM;
                n_result.result_slot = SW'(r_victim);
                if (r_dirty[r_victim]) begin
                    n_result.writeback       = 1'b1;
                    n_result.wb_file_id      = r_file[r_victim];
                    n_result.wb_block_number = r_block[r_victim];
                end
            end else begin
                n_result.status = bpr_pkg::ST_NONE;
            end
        end else if (i_cmd.rstep) begin
            n_result.status          = bpr_pkg::ST_DONE;
            n_result.result_slot     = SW'(r_idx);
            n_result.writeback       = 1'b1;
            n_result.wb_file_id      = r_file[r_idx];
            n_result.wb_block_number = r_block[r_idx];
            n_result.last            = 1'b0;
        end else begin
            n_result.status = bpr_pkg::ST_DONE;
        end
    end

    always_ff @(posedge i_clk) begin
        r_result <= n_result;
    end

    assign o_valid  = r_out_valid;
    assign o_result = r_result;

endmodule

// ----- rtl/buffer_pool_replacement_unit.sv -----
// Buffer-pool directory with least-frequently-used replacement.
// A load that hits or finds a free entry, and every slot command: busy is high only in the
// resolve or slot-command state right after the start transfer; the result strobe follows it.
// A load that misses in a full directory walks the entries for the victim, one per cycle.
// A release walks the entries one per cycle, then closes.
// Synchronous reset empties the directory and sets the count limit to 100; results cannot stall.
module buffer_pool_replacement_unit #(
    parameter int ENTRIES = bpr_pkg::ENTRIES_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  bpr_pkg::t_item              i_item,
    input  logic                        i_cfg_we,
    input  logic [bpr_pkg::COUNT_W-1:0] i_cfg_data,
    output logic                        o_valid,
    output bpr_pkg::t_result            o_result
);

    bpr_pkg::t_dp_cmd dp_cmd;
    bpr_pkg::t_dp_sts dp_sts;

    bpr_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_cmd   (i_item.command),
        .i_sts   (dp_sts),
        .o_busy  (busy),
        .o_cmd   (dp_cmd)
    );

    bpr_datapath #(
        .ENTRIES (ENTRIES)
    ) u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (dp_cmd),
        .i_item     (i_item),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .o_sts      (dp_sts),
        .o_valid    (o_valid),
        .o_result   (o_result)
    );

endmodule
